// File: design/hashed_lru_cache_macros.svh
// Assertion macros for the hashed LRU cache.
// Used by files that carry concurrent checks; expects clk and rst in scope.
`ifndef HASHED_LRU_CACHE_MACROS_SVH
`define HASHED_LRU_CACHE_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define HLC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define HLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/hlc_pkg.sv
// Shared types, codes and helpers for the hashed LRU cache.
// No dependencies.
`timescale 1ns / 1ps
package hlc_pkg;

  localparam int DEF_ENTRIES = 64;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_LENGTH   = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_HEADW, S_WALK, S_CMP, S_DISP,
    S_EKEY, S_EKEYW, S_EUNCH, S_URD, S_UWR, S_SETKEY, S_LINK,
    S_VRD, S_VWR, S_P1, S_P2, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_LOOK, PH_INS1, PH_EVICT, PH_INS2
  } phase_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_data;
    logic        evicted;
  } hlc_res_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) m[8*i +: 8] = BYTE_MASK;
    end
    return m;
  endfunction

endpackage

// File: design/hlc_out_reg.sv
// Result holding register for the hashed LRU cache.
// Depends on hlc_pkg for the result struct.
`timescale 1ns / 1ps
module hlc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  hlc_pkg::hlc_res_t res_in,
  input  logic              out_stall,
  output logic              out_valid,
  output hlc_pkg::hlc_res_t res_q,
  output logic              free
);
  import hlc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_q <= res_in;
  end

  assign free = !out_valid || !out_stall;

endmodule

// File: design/hashed_lru_cache.sv
// Top level of the hashed LRU key/value cache: sequencer and state memories.
// Depends on hlc_pkg, hlc_out_reg and hashed_lru_cache_macros.svh.
`timescale 1ns / 1ps
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  config  | cfg_we                | cfg_data (unit_bytes)
//  input   | in_valid / in_stall   | cmd, key_lo, key_hi, write_data, byte_count
//  output  | out_valid / out_stall | status, read_data, evicted
//
// One item at a time. The bucket is sum mod ENTRIES by reciprocal multiply.
// An insert with eviction walks its own chain, the victim's chain, then its
// own chain again; a refused insert goes straight to the result load.
// After reset a clearing pass over all ENTRIES slots holds in_stall high.
// Results wait in an output register; a full one that is stalled holds the
// sequencer in S_DONE.
module hashed_lru_cache #(
  parameter int ENTRIES = hlc_pkg::DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] key_lo,
  input  logic [31:0] key_hi,
  input  logic [63:0] write_data,
  input  logic [3:0]  byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] read_data,
  output logic        evicted
);
  import hlc_pkg::*;
  `include "hashed_lru_cache_macros.svh"

  localparam int BW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] NULL_SLOT = IW'(ENTRIES);
  localparam logic [BW-1:0] LAST = BW'(ENTRIES - 1);
  // floor(2^32 / ENTRIES): the quotient estimate is at most one short
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(ENTRIES));
  localparam logic [31:0] MOD   = 32'(ENTRIES);

  state_t state, state_next;
  phase_t phase;

  logic [3:0]    unit_bytes;
  logic [3:0]    unit;
  logic          r_cmd;
  logic [31:0]   r_lo, r_hi;
  logic [63:0]   r_wd;
  logic [3:0]    r_cnt;
  logic [31:0]   hsum;
  logic [1:0]    hcnt;
  logic [63:0]   hprod;
  logic [31:0]   hq, hr, hred;
  logic [BW-1:0] wb, nb, clr_idx;
  logic [63:0]   ckey;
  logic [IW-1:0] cur, prev, slot, hit_next, n;
  logic          found;
  logic [IW-1:0] fill_count, newest_slot, oldest_slot;
  logic [63:0]   rd_val;
  logic          ev;
  logic [1:0]    res_status;
  logic          refuse;

  // state memories
  logic [IW-1:0] head_mem  [ENTRIES];
  logic [63:0]   key_mem   [ENTRIES];
  logic [IW-1:0] next_mem  [ENTRIES];
  logic [IW-1:0] newer_mem [ENTRIES];
  logic [IW-1:0] older_mem [ENTRIES];
  logic [63:0]   val_mem   [ENTRIES];

  logic [BW-1:0] head_ra, key_ra, next_ra, newer_ra, older_ra, val_ra;
  logic [IW-1:0] head_q, next_q, newer_q, older_q;
  logic [63:0]   key_q, val_q;
  logic          head_we, key_we, next_we, newer_we, older_we, val_we;
  logic [BW-1:0] head_wa, key_wa, next_wa, newer_wa, older_wa, val_wa;
  logic [IW-1:0] head_wd, next_wd, newer_wd, older_wd;
  logic [63:0]   key_wd, val_wd;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_q <= head_mem[head_ra];
  end
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    key_q <= key_mem[key_ra];
  end
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_q <= next_mem[next_ra];
  end
  always_ff @(posedge clk) begin
    if (newer_we) newer_mem[newer_wa] <= newer_wd;
    newer_q <= newer_mem[newer_ra];
  end
  always_ff @(posedge clk) begin
    if (older_we) older_mem[older_wa] <= older_wd;
    older_q <= older_mem[older_ra];
  end
  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    val_q <= val_mem[val_ra];
  end

  // output register
  hlc_res_t res, res_q;
  logic     out_load, out_free;

  assign res = '{status: res_status, read_data: rd_val, evicted: ev};

  hlc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .res_in    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_q     (res_q),
    .free      (out_free)
  );

  assign status    = res_q.status;
  assign read_data = res_q.read_data;
  assign evicted   = res_q.evicted;

  assign in_stall = (state != S_IDLE);

  // unit sizes above eight act as eight
  assign unit   = (unit_bytes > 4'd8) ? 4'd8 : unit_bytes;
  assign refuse = (cmd == CMD_INSERT) && ((byte_count == 4'd0) || (byte_count > unit));

  // bucket = sum mod ENTRIES: quotient estimate, subtract, one correction
  assign hprod = {32'b0, hsum} * {32'b0, RECIP};
  assign hred  = (hr >= MOD) ? hr - MOD : hr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    head_we  = 1'b0; head_wa  = '0; head_wd  = '0; head_ra  = '0;
    key_we   = 1'b0; key_wa   = '0; key_wd   = '0; key_ra   = '0;
    next_we  = 1'b0; next_wa  = '0; next_wd  = '0; next_ra  = '0;
    newer_we = 1'b0; newer_wa = '0; newer_wd = '0; newer_ra = '0;
    older_we = 1'b0; older_wa = '0; older_wd = '0; older_ra = '0;
    val_we   = 1'b0; val_wa   = '0; val_wd   = '0; val_ra   = '0;
    case (state)
      S_CLEAR: begin
        head_we = 1'b1; head_wa = clr_idx; head_wd = NULL_SLOT;
        val_we  = 1'b1; val_wa  = clr_idx; val_wd  = '0;
        if (clr_idx == LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = refuse ? S_DONE : S_HASH;
      end
      S_HASH: begin
        if (hcnt == 2'd2) state_next = S_HEAD;
      end
      S_HEAD: begin
        head_ra    = wb;
        state_next = S_HEADW;
      end
      S_HEADW: state_next = S_WALK;
      S_WALK: begin
        if (cur >= NULL_SLOT || n >= NULL_SLOT) begin
          state_next = S_DISP;
        end else begin
          key_ra     = cur[BW-1:0];
          next_ra    = cur[BW-1:0];
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = (key_q == ckey) ? S_DISP : S_WALK;
      end
      S_DISP: begin
        case (phase)
          PH_LOOK:  state_next = found ? S_URD : S_DONE;
          PH_INS1: begin
            if (found) state_next = S_DONE;
            else if (fill_count < NULL_SLOT) state_next = S_SETKEY;
            else state_next = S_EKEY;
          end
          PH_EVICT: state_next = (found && cur == slot) ? S_EUNCH : S_URD;
          default:  state_next = S_LINK;
        endcase
      end
      S_EKEY: begin
        key_ra     = slot[BW-1:0];
        state_next = S_EKEYW;
      end
      S_EKEYW: state_next = S_HASH;
      S_EUNCH: begin
        // drop the victim from its chain
        if (prev < NULL_SLOT) begin
          next_we = 1'b1; next_wa = prev[BW-1:0]; next_wd = hit_next;
        end else begin
          head_we = 1'b1; head_wa = wb; head_wd = hit_next;
        end
        state_next = S_URD;
      end
      S_URD: begin
        newer_ra   = slot[BW-1:0];
        older_ra   = slot[BW-1:0];
        val_ra     = slot[BW-1:0];
        state_next = S_UWR;
      end
      S_UWR: begin
        // recency unlink; the slot's own links are rewritten by the push
        if (newer_q < NULL_SLOT) begin
          older_we = 1'b1; older_wa = newer_q[BW-1:0]; older_wd = older_q;
        end
        if (older_q < NULL_SLOT) begin
          newer_we = 1'b1; newer_wa = older_q[BW-1:0]; newer_wd = newer_q;
        end
        state_next = (phase == PH_EVICT) ? S_SETKEY : S_P1;
      end
      S_SETKEY: begin
        key_we  = 1'b1; key_wa  = slot[BW-1:0]; key_wd  = {r_hi, r_lo};
        next_we = 1'b1; next_wa = slot[BW-1:0]; next_wd = NULL_SLOT;
        state_next = S_HEAD;
      end
      S_LINK: begin
        // append to the tail of the new key's chain
        if (prev < NULL_SLOT) begin
          next_we = 1'b1; next_wa = prev[BW-1:0]; next_wd = slot;
        end else begin
          head_we = 1'b1; head_wa = nb; head_wd = slot;
        end
        state_next = S_VRD;
      end
      S_VRD: begin
        val_ra     = slot[BW-1:0];
        state_next = S_VWR;
      end
      S_VWR: begin
        val_we = 1'b1;
        val_wa = slot[BW-1:0];
        val_wd = (val_q & ~byte_mask(r_cnt)) | (r_wd & byte_mask(r_cnt));
        state_next = S_P1;
      end
      S_P1: begin
        older_we = 1'b1; older_wa = slot[BW-1:0]; older_wd = newest_slot;
        newer_we = 1'b1; newer_wa = slot[BW-1:0]; newer_wd = NULL_SLOT;
        state_next = S_P2;
      end
      S_P2: begin
        if (newest_slot < NULL_SLOT) begin
          newer_we = 1'b1; newer_wa = newest_slot[BW-1:0]; newer_wd = slot;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_bytes  <= 4'd8;
      clr_idx     <= '0;
      fill_count  <= '0;
      newest_slot <= NULL_SLOT;
      oldest_slot <= NULL_SLOT;
      phase       <= PH_LOOK;
    end else begin
      if (cfg_we) unit_bytes <= cfg_data;
      case (state)
        S_CLEAR: clr_idx <= clr_idx + 1'b1;
        S_IDLE: begin
          if (in_valid) phase <= (cmd == CMD_LOOKUP) ? PH_LOOK : PH_INS1;
        end
        S_DISP: begin
          if (phase == PH_INS1 && !found && fill_count < NULL_SLOT)
            fill_count <= fill_count + 1'b1;
        end
        S_EKEYW:  phase <= PH_EVICT;
        S_SETKEY: phase <= PH_INS2;
        S_UWR: begin
          if (newer_q >= NULL_SLOT) newest_slot <= older_q;
          if (older_q >= NULL_SLOT) oldest_slot <= newer_q;
        end
        S_P2: begin
          if (newest_slot >= NULL_SLOT) oldest_slot <= slot;
          newest_slot <= slot;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          r_cmd      <= cmd;
          r_lo       <= key_lo;
          r_hi       <= key_hi;
          r_wd       <= write_data;
          r_cnt      <= byte_count;
          ckey       <= {key_hi, key_lo};
          hsum       <= key_lo + key_hi;
          hcnt       <= '0;
          res_status <= refuse ? STAT_LENGTH : STAT_OK;
          rd_val     <= '0;
          ev         <= 1'b0;
        end
      end
      S_HASH: begin
        hcnt <= hcnt + 1'b1;
        case (hcnt)
          2'd0: hq <= hprod[63:32];
          2'd1: hr <= hsum - hq * MOD;
          default: begin
            wb <= hred[BW-1:0];
            if (phase != PH_EVICT) nb <= hred[BW-1:0];
          end
        endcase
      end
      S_HEADW: begin
        cur  <= head_q;
        prev <= NULL_SLOT;
        n    <= '0;
      end
      S_WALK: begin
        if (cur >= NULL_SLOT || n >= NULL_SLOT) found <= 1'b0;
      end
      S_CMP: begin
        if (key_q == ckey) begin
          found    <= 1'b1;
          hit_next <= next_q;
        end else begin
          prev <= cur;
          cur  <= next_q;
          n    <= n + 1'b1;
        end
      end
      S_DISP: begin
        case (phase)
          PH_LOOK: begin
            if (found) slot <= cur;
            else res_status <= STAT_NOTFOUND;
          end
          PH_INS1: begin
            if (!found) begin
              if (fill_count < NULL_SLOT) slot <= fill_count;
              else slot <= (oldest_slot < NULL_SLOT) ? oldest_slot : '0;
            end
          end
          default: ;
        endcase
      end
      S_EKEYW: begin
        ckey <= key_q;
        hsum <= key_q[31:0] + key_q[63:32];
        hcnt <= '0;
      end
      S_UWR: begin
        if (phase == PH_LOOK) rd_val <= val_q & byte_mask(unit);
        if (phase == PH_EVICT) ev <= 1'b1;
      end
      S_SETKEY: begin
        ckey <= {r_hi, r_lo};
        wb   <= nb;
      end
      default: ;
    endcase
  end

  `HLC_ASSERT_ALWAYS(a_lru_ends, (newest_slot == NULL_SLOT) == (oldest_slot == NULL_SLOT), "LRU list ends disagree on emptiness")
  `HLC_ASSERT_ALWAYS(a_fill_range, fill_count <= NULL_SLOT, "fill count beyond entry count")
  `HLC_ASSERT_IMP(a_evict_full, out_load && res.evicted && r_cmd == CMD_INSERT, fill_count == NULL_SLOT, "eviction with free slots left")

endmodule

// File: dv/hashed_lru_cache_checker.sv
// Checker for the hashed LRU cache: watches both channels, predicts each result.
// Depends on hlc_pkg; instantiated beside the block by hashed_lru_cache_tb.
`timescale 1ns / 1ps
module hashed_lru_cache_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] key_lo,
  input  logic [31:0] key_hi,
  input  logic [63:0] write_data,
  input  logic [3:0]  byte_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [63:0] read_data,
  input  logic        evicted,
  output int          fail_count,
  output int          pending,
  output int          hit_count,
  output int          evict_count
);
  import hlc_pkg::*;

  localparam int N = DEF_ENTRIES;
  localparam int NIL = N;

  logic [3:0]  unit_q;
  int          head_q  [N];
  logic [31:0] klo_q   [N];
  logic [31:0] khi_q   [N];
  int          chain_q [N];
  int          newer_q [N];
  int          older_q [N];
  logic [63:0] val_q   [N];
  int          fill_q, newest_q, oldest_q;
  hlc_res_t    expected_results[$];

  function automatic logic [63:0] mask_of(int n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) if (i < n) m[8*i +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic int bucket(logic [31:0] lo, logic [31:0] hi);
    logic [31:0] s;
    s = lo + hi;
    return int'(s % N);
  endfunction

  // Returns the slot or NIL; prev gets the link before it (or chain tail on miss).
  function automatic int find_key(int b, logic [31:0] lo, logic [31:0] hi,
                                  output int prev);
    int p, cur, n;
    p = NIL; cur = head_q[b]; n = 0;
    while (cur < N && n < N) begin
      if (klo_q[cur] == lo && khi_q[cur] == hi) begin
        prev = p;
        return cur;
      end
      p = cur; cur = chain_q[cur]; n++;
    end
    prev = p;
    return NIL;
  endfunction

  function automatic void unlink(int s);
    int nw, od;
    nw = newer_q[s]; od = older_q[s];
    if (nw < N) older_q[nw] = od; else newest_q = od;
    if (od < N) newer_q[od] = nw; else oldest_q = nw;
    newer_q[s] = NIL; older_q[s] = NIL;
  endfunction

  function automatic void make_newest(int s);
    newer_q[s] = NIL;
    older_q[s] = newest_q;
    if (newest_q < N) newer_q[newest_q] = s; else oldest_q = s;
    newest_q = s;
  endfunction

  function automatic hlc_res_t predict_access(logic c, logic [31:0] lo, logic [31:0] hi,
                                              logic [63:0] wd, logic [3:0] cnt);
    hlc_res_t r;
    int unit, b, prev, slot, ob, op, os;
    logic [63:0] m;
    r = '0;
    unit = (unit_q > 8) ? 8 : int'(unit_q);
    b = bucket(lo, hi);
    if (c == CMD_LOOKUP) begin
      slot = find_key(b, lo, hi, prev);
      if (slot >= N) r.status = STAT_NOTFOUND;
      else begin
        unlink(slot);
        make_newest(slot);
        r.read_data = val_q[slot] & mask_of(unit);
      end
    end else if (cnt == 0 || int'(cnt) > unit) begin
      r.status = STAT_LENGTH;
    end else if (find_key(b, lo, hi, prev) < N) begin
      r.status = STAT_OK;
    end else begin
      if (fill_q < N) begin
        slot = fill_q;
        fill_q++;
      end else begin
        slot = (oldest_q < N) ? oldest_q : 0;
        ob = bucket(klo_q[slot], khi_q[slot]);
        os = find_key(ob, klo_q[slot], khi_q[slot], op);
        if (os == slot) begin
          if (op < N) chain_q[op] = chain_q[slot];
          else head_q[ob] = chain_q[slot];
        end
        unlink(slot);
        r.evicted = 1'b1;
      end
      klo_q[slot] = lo;
      khi_q[slot] = hi;
      chain_q[slot] = NIL;
      void'(find_key(b, lo, hi, prev));
      if (prev < N) chain_q[prev] = slot; else head_q[b] = slot;
      m = mask_of(int'(cnt));
      val_q[slot] = (val_q[slot] & ~m) | (wd & m);
      make_newest(slot);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    hlc_res_t e;
    int errs;
    errs = 0;
    if (rst) begin
      unit_q <= 4'd8;
      for (int i = 0; i < N; i++) begin
        head_q[i] = NIL; chain_q[i] = NIL; newer_q[i] = NIL; older_q[i] = NIL;
        val_q[i] = '0; klo_q[i] = '0; khi_q[i] = '0;
      end
      fill_q = 0; newest_q = NIL; oldest_q = NIL;
      expected_results.delete();
      fail_count <= 0; pending <= 0; hit_count <= 0; evict_count <= 0;
    end else begin
      if (cfg_we) unit_q <= cfg_data;
      if (in_valid && !in_stall) begin
        e = predict_access(cmd, key_lo, key_hi, write_data, byte_count);
        expected_results.push_back(e);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          errs++;
        end else begin
          e = expected_results.pop_front();
          if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errs++;
          end
          if (read_data !== e.read_data) begin
            $error("read_data: expected %h, got %h", e.read_data, read_data);
            errs++;
          end
          if (evicted !== e.evicted) begin
            $error("evicted: expected %0d, got %0d", e.evicted, evicted);
            errs++;
          end
          if (e.status == STAT_OK && e.read_data != 0) hit_count <= hit_count + 1;
          if (e.evicted) evict_count <= evict_count + 1;
        end
      end
      fail_count <= fail_count + errs;
      pending <= expected_results.size();
    end
  end
endmodule

// File: dv/hashed_lru_cache_tb.sv
// Testbench top for the hashed LRU cache: clock, reset, stimulus and verdict.
// Depends on hlc_pkg, hashed_lru_cache and hashed_lru_cache_checker.
`timescale 1ns / 1ps
module hashed_lru_cache_tb;
  import hlc_pkg::*;

  localparam int WATCHDOG = 20000;  // idle cycles: eviction walk plus stalls
  localparam int KEYS = 96;         // pool larger than the 64 slots forces eviction

  logic        clk, rst;
  logic        cfg_we;
  logic [3:0]  cfg_data;
  logic        in_valid, in_stall;
  logic        cmd;
  logic [31:0] key_lo, key_hi;
  logic [63:0] write_data;
  logic [3:0]  byte_count;
  logic        out_valid, out_stall;
  logic [1:0]  status;
  logic [63:0] read_data;
  logic        evicted;
  int          fail_count, pending, hit_count, evict_count;
  int          items_sent, idle_cycles;
  logic        drain_on;

  // Key pool: several keys share a bucket so chains get long.
  logic [31:0] pool_lo [KEYS];
  logic [31:0] pool_hi [KEYS];

  hashed_lru_cache DUT (.*);

  hashed_lru_cache_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: no handshake for too long ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stall lengths per item, with calm stretches.
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge clk iff !rst);
    forever begin
      gap = drain_on ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk iff out_valid);
    end
  end

  task automatic send_item(logic c, logic [31:0] lo, logic [31:0] hi,
                           logic [63:0] wd, logic [3:0] cnt, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    key_lo     <= lo;
    key_hi     <= hi;
    write_data <= wd;
    byte_count <= cnt;
    @(posedge clk iff !in_stall);
    items_sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Idle gap: usually random, a quarter of items back to back.
  function automatic int next_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  // Waits for every result, then a margin before the next phase.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_unit(logic [3:0] u);
    cfg_we   <= 1'b1;
    cfg_data <= u;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int k;
    logic [3:0] cnt;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, KEYS - 1);
      cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 8));
      case ($urandom_range(0, 9))
        0: send_item(1'($urandom()), $urandom(), $urandom(), rand64(),
                     4'($urandom()), next_gap());
        1, 2, 3, 4: send_item(CMD_INSERT, pool_lo[k], pool_hi[k], rand64(), cnt, next_gap());
        default: send_item(CMD_LOOKUP, pool_lo[k], pool_hi[k], rand64(), cnt, next_gap());
      endcase
    end
  endtask

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_data = '0; in_valid = 1'b0; cmd = CMD_INSERT;
    key_lo = '0; key_hi = '0; write_data = '0; byte_count = '0;
    items_sent = 0; drain_on = 1'b0;
    for (int i = 0; i < KEYS; i++) begin
      // A third of keys crowd into four buckets; the rest spread at random.
      pool_lo[i] = $urandom();
      pool_hi[i] = (i % 3 == 0) ? (32'($urandom_range(0, 3)) - pool_lo[i]) : $urandom();
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, refusals, duplicate insert, miss, stale bytes.
    send_item(CMD_LOOKUP, 32'h0, 32'h0, '0, 4'd0, 0);                     // miss on empty
    send_item(CMD_INSERT, 32'h0, 32'h0, '1, 4'd0, 0);                     // zero count
    send_item(CMD_INSERT, 32'h0, 32'h0, '1, 4'd9, 0);                     // above unit
    send_item(CMD_INSERT, 32'h0, 32'h0, '1, 4'd15, 1);
    send_item(CMD_INSERT, 32'h0, 32'h0, '1, 4'd8, 0);
    send_item(CMD_INSERT, '1, '1, 64'h0123_4567_89AB_CDEF, 4'd8, 0);
    send_item(CMD_INSERT, '1, 32'h1, 64'hAAAA_5555_AAAA_5555, 4'd1, 2); // same bucket as 0,0
    send_item(CMD_INSERT, 32'h0, 32'h0, '0, 4'd8, 0);                    // present key
    send_item(CMD_LOOKUP, 32'h0, 32'h0, '0, 4'd0, 0);
    send_item(CMD_LOOKUP, '1, 32'h1, '0, 4'd0, 0);
    send_item(CMD_LOOKUP, '1, '1, '0, 4'd0, 3);
    send_item(CMD_LOOKUP, 32'h1234, 32'h0, '0, 4'd0, 0);                 // miss in an empty bucket
    drain();
    write_unit(4'd0);                                                    // every insert refused
    send_item(CMD_INSERT, 32'h5, 32'h5, '1, 4'd1, 0);
    send_item(CMD_LOOKUP, '1, '1, '0, 4'd0, 0);
    drain();
    write_unit(4'd15);                                                   // acts as eight
    send_item(CMD_LOOKUP, '1, '1, '0, 4'd0, 0);
    drain();
    write_unit(4'd3);
    send_item(CMD_LOOKUP, '1, '1, '0, 4'd0, 0);
    send_item(CMD_INSERT, 32'h7, 32'h9, '0, 4'd4, 0);                    // refused
    send_item(CMD_INSERT, 32'h7, 32'h9, '1, 4'd3, 0);
    drain();

    // Random phases across unit sizes, extremes included.
    write_unit(4'd8);
    random_phase(500);
    drain();
    write_unit(4'd1);
    random_phase(200);
    drain();
    write_unit(4'($urandom_range(2, 7)));
    random_phase(250);
    drain();
    write_unit(4'd15);
    random_phase(330);

    drain_on = 1'b1;
    drain();
    $display("%0d items sent; %0d lookup hits with data, %0d evictions seen",
             items_sent, hit_count, evict_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
